@@ rtl/sli_pkg.sv @@
package sli_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP    = 2'd2
  } cmd_t;

  localparam int ValueWidth = 32;

  typedef logic signed [ValueWidth-1:0] value_t;

  // Operation broadcast along the row; at most one of the enables is high.
  typedef struct packed {
    logic   ins;
    logic   del;
    logic   pop;
    value_t value;
  } cell_op_t;

  // Comparison flags each cell reports about its own entry.
  typedef struct packed {
    logic ge;
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

@@ rtl/sli_if.sv @@
interface sli_cmd_if;
  import sli_pkg::*;
  logic         valid;
  logic         ready;
  logic [1:0]   cmd;
  value_t       value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface sli_res_if #(
  parameter int CW = 5
);
  logic          valid;
  logic          ready;
  logic          ok;
  logic [CW-1:0] count;

  modport source (output valid, output ok, output count, input ready);
  modport sink (input valid, input ok, input count, output ready);
endinterface

@@ rtl/sli_cell.sv @@
module sli_cell
  import sli_pkg::*;
(
  input  logic        clk,
  input  cell_op_t    op,
  input  logic        valid,
  input  logic        left_ge,
  input  value_t      left_entry,
  input  value_t      right_entry,
  output value_t      entry,
  output cell_flags_t flags
);

  value_t entry_next;

  always_comb begin
    flags.ge = valid && (entry <= op.value);
    flags.lt = valid && (entry < op.value);
    flags.eq = valid && (entry == op.value);
  end

  // An insert keeps entries not above the new value, drops the new value into the
  // first slot past them and shifts the rest up by one. Removals close the gap
  // by pulling from the right-hand neighbour.
  always_comb begin
    entry_next = entry;
    if (op.ins) begin
      if (!flags.ge) begin
        entry_next = left_ge ? op.value : left_entry;
      end
    end else if (op.del) begin
      if (!flags.lt) begin
        entry_next = right_entry;
      end
    end else if (op.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ rtl/sorted_list_insert_remove_top.sv @@
// Channel  Dir  Payload                       Role
// req      in   cmd[1:0], value[31:0] signed  insert, remove value, remove smallest
// rsp      out  ok, count[CW-1:0]             success flag and entry count afterwards
//
// Every command is applied in the row of DEPTH compare-and-shift cells, and a
// new command is taken each cycle while the result register drains.
// The result is captured in the register with the transfer on req.
// A stalled result holds req off until it is taken; req ready is free otherwise.
// Synchronous reset empties the list at once; stored values need no clearing.
module sorted_list_insert_remove_top
  import sli_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  sli_cmd_if.sink    req,
  sli_res_if.source  rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          res_valid;
  logic          res_ok;
  logic [CW-1:0] res_count;

  logic          accept;
  logic          ok_next;
  logic          full;
  logic          empty;
  logic          found;
  cell_op_t      op;

  value_t        entry_w [DEPTH];
  cell_flags_t   flags_w [DEPTH];
  logic [DEPTH-1:0] eq_vec;

  assign req.ready = !res_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign found     = |eq_vec;

  always_comb begin
    ok_next = 1'b0;
    unique case (req.cmd)
      CMD_INSERT: ok_next = !full;
      CMD_REMOVE: ok_next = found;
      CMD_POP:    ok_next = !empty;
      default:    ok_next = 1'b0;
    endcase
  end

  always_comb begin
    op.value = req.value;
    op.ins   = accept && ok_next && (req.cmd == CMD_INSERT);
    op.del   = accept && ok_next && (req.cmd == CMD_REMOVE);
    op.pop   = accept && ok_next && (req.cmd == CMD_POP);
    count_next = count;
    if (op.ins) begin
      count_next = count + CW'(1);
    end else if (op.del || op.pop) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   left_ge;
    value_t left_entry;
    value_t right_entry;

    if (i == 0) begin : g_first
      assign left_ge    = 1'b1;
      assign left_entry = req.value;
    end else begin : g_mid
      assign left_ge    = flags_w[i-1].ge;
      assign left_entry = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry_w[i];
    end else begin : g_right
      assign right_entry = entry_w[i+1];
    end

    sli_cell u_cell (
      .clk         (clk),
      .op          (op),
      .valid       (count > CW'(i)),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_w[i]),
      .flags       (flags_w[i])
    );

    assign eq_vec[i] = flags_w[i].eq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_ok    <= ok_next;
      res_count <= count_next;
    end
  end

  assign rsp.valid = res_valid;
  assign rsp.ok    = res_ok;
  assign rsp.count = res_count;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds the list depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    !(count >= CW'(2)) || (entry_w[0] <= entry_w[1]))
    else $error("first two entries out of order");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    accept && (req.cmd == CMD_INSERT) && full |=> !res_ok && $stable(count))
    else $error("insert into a full list changed it");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_count == count))
    else $error("reported count differs from the stored count");

endmodule
